/* rtl/hidrds_pkg.sv */
// Shared types, constants and helpers for the HID report descriptor scanner.
// Used by hidrds_parser and the top level; depends on nothing else.
package hidrds_pkg;

    localparam logic [31:0] MAX16 = 32'd65535;

    typedef enum logic [1:0] {
        KIND_INPUT,
        KIND_OUTPUT,
        KIND_FEATURE
    } t_report_kind;

    // One completed main item or end-of-descriptor marker from the parser.
    typedef struct packed {
        logic         main;
        t_report_kind kind;
        logic [31:0]  size;
        logic [31:0]  count;
        logic         id_set;
        logic         last;
        logic [15:0]  upage;
        logic [15:0]  usage;
    } t_event;

    function automatic logic [15:0] clip16(input logic [31:0] m);
        return (m > MAX16) ? 16'hffff : m[15:0];
    endfunction

    function automatic logic ok16(input logic [31:0] m);
        return (m != 32'd0) && (m <= MAX16);
    endfunction

endpackage

/* rtl/hidrds_parser.sv */
// Byte-level item parser: prefix decode, data byte gathering, long item skip,
// and the global/local item state. Depends on hidrds_pkg.
module hidrds_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,
    output hidrds_pkg::t_event  o_event
);

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_SHORT,
        PH_LONG_LEN,
        PH_LONG_TAG,
        PH_LONG_DATA
    } t_phase;

    localparam logic [7:0] LONG_PREFIX      = 8'hfe;
    localparam logic [1:0] TYPE_MAIN        = 2'd0;
    localparam logic [1:0] TYPE_GLOBAL      = 2'd1;
    localparam logic [1:0] TYPE_LOCAL       = 2'd2;
    localparam logic [3:0] TAG_USAGE_PAGE   = 4'd0;
    localparam logic [3:0] TAG_REPORT_SIZE  = 4'd7;
    localparam logic [3:0] TAG_REPORT_ID    = 4'd8;
    localparam logic [3:0] TAG_REPORT_COUNT = 4'd9;
    localparam logic [3:0] TAG_USAGE        = 4'd0;
    localparam logic [3:0] TAG_INPUT        = 4'd8;
    localparam logic [3:0] TAG_OUTPUT       = 4'd9;
    localparam logic [3:0] TAG_FEATURE      = 4'd11;
    localparam logic [1:0] SIZE_CODE_FOUR   = 2'd3;

    t_phase      r_phase, n_phase;
    logic [5:0]  r_kind, n_kind;
    logic [7:0]  r_left, n_left;
    logic [31:0] r_acc, n_acc;
    logic [1:0]  r_pos, n_pos;
    logic [31:0] r_size, n_size;
    logic [31:0] r_count, n_count;
    logic [7:0]  r_id, n_id;
    logic [15:0] r_upage, n_upage;
    logic        r_upage_seen, n_upage_seen;
    logic [15:0] r_usage, n_usage;
    logic        r_usage_seen, n_usage_seen;

    logic        done;
    logic [5:0]  kind;
    logic [31:0] value;
    logic [31:0] shifted;
    logic [1:0]  item_type;
    logic [3:0]  tag;

    always_comb begin
        n_phase      = r_phase;
        n_kind       = r_kind;
        n_left       = r_left;
        n_acc        = r_acc;
        n_pos        = r_pos;
        n_size       = r_size;
        n_count      = r_count;
        n_id         = r_id;
        n_upage      = r_upage;
        n_upage_seen = r_upage_seen;
        n_usage      = r_usage;
        n_usage_seen = r_usage_seen;
        done         = 1'b0;
        kind         = r_kind;
        value        = r_acc;
        shifted      = {24'd0, i_data_byte} << {r_pos, 3'b000};

        o_event      = '0;

        unique case (r_phase)
            PH_SHORT: begin
                n_acc  = r_acc | shifted;
                n_pos  = r_pos + 2'd1;
                n_left = r_left - 8'd1;
                if (n_left == 8'd0) begin
                    done    = 1'b1;
                    value   = n_acc;
                    n_phase = PH_PREFIX;
                end
            end
            PH_LONG_LEN: begin
                n_left  = i_data_byte;
                n_phase = PH_LONG_TAG;
            end
            PH_LONG_TAG: begin
                n_phase = (r_left == 8'd0) ? PH_PREFIX : PH_LONG_DATA;
            end
            PH_LONG_DATA: begin
                n_left = r_left - 8'd1;
                if (n_left == 8'd0) begin
                    n_phase = PH_PREFIX;
                end
            end
            default: begin
                if (i_data_byte == LONG_PREFIX) begin
                    n_phase = PH_LONG_LEN;
                end else begin
                    n_kind = i_data_byte[7:2];
                    kind   = i_data_byte[7:2];
                    n_acc  = 32'd0;
                    n_pos  = 2'd0;
                    value  = 32'd0;
                    n_left = (i_data_byte[1:0] == SIZE_CODE_FOUR) ? 8'd4
                                                                  : {6'd0, i_data_byte[1:0]};
                    if (i_data_byte[1:0] == 2'd0) begin
                        done    = 1'b1;
                        n_phase = PH_PREFIX;
                    end else begin
                        n_phase = PH_SHORT;
                    end
                end
            end
        endcase

        item_type = kind[1:0];
        tag       = kind[5:2];

        if (done) begin
            if (item_type == TYPE_GLOBAL) begin
                if (tag == TAG_USAGE_PAGE) begin
                    if (!r_upage_seen) begin
                        n_upage      = value[15:0];
                        n_upage_seen = 1'b1;
                    end
                end else if (tag == TAG_REPORT_SIZE) begin
                    n_size = value;
                end else if (tag == TAG_REPORT_ID) begin
                    n_id = value[7:0];
                end else if (tag == TAG_REPORT_COUNT) begin
                    n_count = value;
                end
            end else if (item_type == TYPE_LOCAL) begin
                if (tag == TAG_USAGE && !r_usage_seen) begin
                    n_usage      = value[15:0];
                    n_usage_seen = 1'b1;
                end
            end else if (item_type == TYPE_MAIN) begin
                if (tag == TAG_INPUT) begin
                    o_event.main = 1'b1;
                    o_event.kind = hidrds_pkg::KIND_INPUT;
                end else if (tag == TAG_OUTPUT) begin
                    o_event.main = 1'b1;
                    o_event.kind = hidrds_pkg::KIND_OUTPUT;
                end else if (tag == TAG_FEATURE) begin
                    o_event.main = 1'b1;
                    o_event.kind = hidrds_pkg::KIND_FEATURE;
                end
            end
        end

        o_event.size   = r_size;
        o_event.count  = r_count;
        o_event.id_set = (r_id != 8'd0);
        o_event.last   = i_last_byte;
        o_event.upage  = n_upage;
        o_event.usage  = n_usage;

        // The final byte closes the descriptor; the next byte starts afresh.
        if (i_last_byte) begin
            n_phase      = PH_PREFIX;
            n_kind       = 6'd0;
            n_left       = 8'd0;
            n_acc        = 32'd0;
            n_pos        = 2'd0;
            n_size       = 32'd0;
            n_count      = 32'd0;
            n_id         = 8'd0;
            n_upage      = 16'd0;
            n_upage_seen = 1'b0;
            n_usage      = 16'd0;
            n_usage_seen = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_PREFIX;
            r_kind       <= 6'd0;
            r_left       <= 8'd0;
            r_acc        <= 32'd0;
            r_pos        <= 2'd0;
            r_size       <= 32'd0;
            r_count      <= 32'd0;
            r_id         <= 8'd0;
            r_upage      <= 16'd0;
            r_upage_seen <= 1'b0;
            r_usage      <= 16'd0;
            r_usage_seen <= 1'b0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_kind       <= n_kind;
            r_left       <= n_left;
            r_acc        <= n_acc;
            r_pos        <= n_pos;
            r_size       <= n_size;
            r_count      <= n_count;
            r_id         <= n_id;
            r_upage      <= n_upage;
            r_upage_seen <= n_upage_seen;
            r_usage      <= n_usage;
            r_usage_seen <= n_usage_seen;
        end
    end

endmodule

/* rtl/hid_report_descriptor_scanner_unit.sv */
// Top level of the HID report descriptor scanner: parser, length pipeline,
// maxima and the summary output register. Depends on hidrds_pkg, hidrds_parser.
//
// Throughput: one descriptor byte per cycle while input stall is low.
// After the last byte is accepted, its summary is registered in turn in the event,
// multiplier, length and output registers.
// Input stall rises only while output stall holds a summary, another end-of-descriptor
// marker waits in the length register and both stages in front of it are occupied.
// Reset (synchronous, active low) clears the parse state, maxima and all valid bits.
module hid_report_descriptor_scanner_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_input_report_bytes,
    output logic        o_input_valid,
    output logic [15:0] o_output_report_bytes,
    output logic        o_output_valid,
    output logic [15:0] o_feature_report_bytes,
    output logic        o_feature_valid,
    output logic [15:0] o_top_usage_page,
    output logic [15:0] o_top_usage,
    output logic [31:0] o_max_any_report_bytes
);

    typedef struct packed {
        logic                     main;
        hidrds_pkg::t_report_kind kind;
        logic [63:0]              product;
        logic                     id_set;
        logic                     last;
        logic [15:0]              upage;
        logic [15:0]              usage;
    } t_prod_stage;

    typedef struct packed {
        logic                     main;
        hidrds_pkg::t_report_kind kind;
        logic [31:0]              len;
        logic                     last;
        logic [15:0]              upage;
        logic [15:0]              usage;
    } t_len_stage;

    hidrds_pkg::t_event ev;
    hidrds_pkg::t_event r_s1;
    logic               r_s1_valid;
    t_prod_stage        r_s2, n_s2;
    logic               r_s2_valid;
    t_len_stage         r_s3, n_s3;
    logic               r_s3_valid;

    logic [31:0] r_max_in, r_max_out, r_max_feat, r_max_any;
    logic [31:0] n_max_in, n_max_out, n_max_feat, n_max_any;
    logic [31:0] r_out_in, r_out_out, r_out_feat, r_out_any;
    logic [15:0] r_out_upage, r_out_usage;
    logic        r_out_valid;

    logic        accept;
    logic        out_free, s3_move, s3_ready, s2_ready, s1_ready, load_out;
    logic [63:0] rounded;
    logic [60:0] bytes;

    assign out_free = !r_out_valid || !i_out_stall;
    assign s3_move  = r_s3_valid && (!r_s3.last || out_free);
    assign s3_ready = !r_s3_valid || s3_move;
    assign s2_ready = !r_s2_valid || s3_ready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign load_out = s3_move && r_s3.last;

    assign o_in_stall = !s1_ready;
    assign accept     = i_in_valid && s1_ready;

    hidrds_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_event     (ev)
    );

    always_comb begin
        n_s2.main    = r_s1.main;
        n_s2.kind    = r_s1.kind;
        n_s2.product = {32'd0, r_s1.size} * {32'd0, r_s1.count};
        n_s2.id_set  = r_s1.id_set;
        n_s2.last    = r_s1.last;
        n_s2.upage   = r_s1.upage;
        n_s2.usage   = r_s1.usage;
    end

    // ceil(bits/8) plus the ID byte folds into one add: (bits + 7 + 8*id) >> 3.
    always_comb begin
        rounded    = r_s2.product + (r_s2.id_set ? 64'd15 : 64'd7);
        bytes      = rounded[63:3];
        n_s3.main  = r_s2.main;
        n_s3.kind  = r_s2.kind;
        n_s3.len   = (|bytes[60:32]) ? 32'hffffffff : bytes[31:0];
        n_s3.last  = r_s2.last;
        n_s3.upage = r_s2.upage;
        n_s3.usage = r_s2.usage;
    end

    always_comb begin
        n_max_in   = r_max_in;
        n_max_out  = r_max_out;
        n_max_feat = r_max_feat;
        n_max_any  = r_max_any;
        if (s3_move && r_s3.main) begin
            unique case (r_s3.kind)
                hidrds_pkg::KIND_INPUT: begin
                    if (r_s3.len > r_max_in) n_max_in = r_s3.len;
                end
                hidrds_pkg::KIND_OUTPUT: begin
                    if (r_s3.len > r_max_out) n_max_out = r_s3.len;
                end
                hidrds_pkg::KIND_FEATURE: begin
                    if (r_s3.len > r_max_feat) n_max_feat = r_s3.len;
                end
                default: begin
                end
            endcase
            if (r_s3.len > r_max_any) n_max_any = r_s3.len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_max_in    <= 32'd0;
            r_max_out   <= 32'd0;
            r_max_feat  <= 32'd0;
            r_max_any   <= 32'd0;
        end else begin
            if (s1_ready) begin
                // Bytes that neither finish an Input, Output or Feature item nor end the
                // descriptor leave a bubble.
                r_s1_valid <= accept && (ev.main || ev.last);
                r_s1       <= ev;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
                r_s2       <= n_s2;
            end
            if (s3_ready) begin
                r_s3_valid <= r_s2_valid;
                r_s3       <= n_s3;
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
                r_out_in    <= n_max_in;
                r_out_out   <= n_max_out;
                r_out_feat  <= n_max_feat;
                r_out_any   <= n_max_any;
                r_out_upage <= r_s3.upage;
                r_out_usage <= r_s3.usage;
                r_max_in    <= 32'd0;
                r_max_out   <= 32'd0;
                r_max_feat  <= 32'd0;
                r_max_any   <= 32'd0;
            end else begin
                if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
                r_max_in   <= n_max_in;
                r_max_out  <= n_max_out;
                r_max_feat <= n_max_feat;
                r_max_any  <= n_max_any;
            end
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_input_report_bytes   = hidrds_pkg::clip16(r_out_in);
    assign o_input_valid          = hidrds_pkg::ok16(r_out_in);
    assign o_output_report_bytes  = hidrds_pkg::clip16(r_out_out);
    assign o_output_valid         = hidrds_pkg::ok16(r_out_out);
    assign o_feature_report_bytes = hidrds_pkg::clip16(r_out_feat);
    assign o_feature_valid        = hidrds_pkg::ok16(r_out_feat);
    assign o_top_usage_page       = r_out_upage;
    assign o_top_usage            = r_out_usage;
    assign o_max_any_report_bytes = r_out_any;

    a_max_cleared_after_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (r_max_any == 32'd0 && r_max_in == 32'd0))
        else $error("maxima not cleared after a summary was loaded");

    a_overall_bounds_kinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_max_any >= r_max_in) && (r_max_any >= r_max_out) && (r_max_any >= r_max_feat))
        else $error("overall maximum below a per-kind maximum");

    a_s1_holds_useful: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_s1.main || r_s1.last))
        else $error("event register holds an item with no effect");

    a_no_stall_when_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> !o_in_stall)
        else $error("input stalled while the output register is empty");

endmodule

/* bench/hidrds_checker.sv */
`timescale 1ns / 1ps
// Bench constants and the scoreboard for the HID report descriptor scanner.
// Watches both channels, predicts each summary and compares it; no RTL dependency.
package hidrds_bench_pkg;

    localparam logic [1:0] ITEM_MAIN      = 2'd0;
    localparam logic [1:0] ITEM_GLOBAL    = 2'd1;
    localparam logic [1:0] ITEM_LOCAL     = 2'd2;
    localparam logic [1:0] ITEM_RESERVED  = 2'd3;
    localparam logic [1:0] SIZE_CODE_FOUR = 2'd3;

    localparam logic [3:0] TAG_USAGE_PAGE     = 4'd0;
    localparam logic [3:0] TAG_USAGE          = 4'd0;
    localparam logic [3:0] TAG_REPORT_SIZE    = 4'd7;
    localparam logic [3:0] TAG_REPORT_ID      = 4'd8;
    localparam logic [3:0] TAG_REPORT_COUNT   = 4'd9;
    localparam logic [3:0] TAG_INPUT          = 4'd8;
    localparam logic [3:0] TAG_OUTPUT         = 4'd9;
    localparam logic [3:0] TAG_COLLECTION     = 4'd10;
    localparam logic [3:0] TAG_FEATURE        = 4'd11;
    localparam logic [3:0] TAG_END_COLLECTION = 4'd12;

    localparam logic [7:0] LONG_ITEM_PREFIX = 8'hfe;

    typedef struct packed {
        logic [15:0] input_bytes;
        logic        input_ok;
        logic [15:0] output_bytes;
        logic        output_ok;
        logic [15:0] feature_bytes;
        logic        feature_ok;
        logic [15:0] upage;
        logic [15:0] usage;
        logic [31:0] any_bytes;
    } t_summary;

endpackage

module hidrds_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [15:0] i_input_report_bytes,
    input  logic        i_input_valid,
    input  logic [15:0] i_output_report_bytes,
    input  logic        i_output_valid,
    input  logic [15:0] i_feature_report_bytes,
    input  logic        i_feature_valid,
    input  logic [15:0] i_top_usage_page,
    input  logic [15:0] i_top_usage,
    input  logic [31:0] i_max_any_report_bytes,
    output int          o_error_count,
    output int          o_pending
);
    import hidrds_bench_pkg::*;

    typedef enum logic [2:0] {
        SCAN_PREFIX,
        SCAN_SHORT_DATA,
        SCAN_LONG_LEN,
        SCAN_LONG_TAG,
        SCAN_LONG_DATA
    } t_scan_phase;

    t_scan_phase scan_phase;
    logic [5:0]  item_bits;
    logic [7:0]  bytes_left;
    logic [31:0] item_value;
    logic [1:0]  data_pos;
    logic [31:0] cur_size;
    logic [31:0] cur_count;
    logic [7:0]  cur_id;
    logic [31:0] max_input;
    logic [31:0] max_output;
    logic [31:0] max_feat;
    logic [31:0] max_any;
    logic [15:0] first_page;
    logic        page_seen;
    logic [15:0] first_usage;
    logic        usage_seen;

    t_summary summary_q[$];
    int       error_count = 0;

    assign o_error_count = error_count;

    function void clear_scan();
        scan_phase  = SCAN_PREFIX;
        item_bits   = '0;
        bytes_left  = '0;
        item_value  = '0;
        data_pos    = '0;
        cur_size    = '0;
        cur_count   = '0;
        cur_id      = '0;
        max_input   = '0;
        max_output  = '0;
        max_feat    = '0;
        max_any     = '0;
        first_page  = '0;
        page_seen   = 1'b0;
        first_usage = '0;
        usage_seen  = 1'b0;
    endfunction

    function logic [15:0] sat16(input logic [31:0] m);
        return (m > 32'd65535) ? 16'hffff : m[15:0];
    endfunction

    function logic in_range16(input logic [31:0] m);
        return (m != 32'd0) && (m <= 32'd65535);
    endfunction

    // Acts on a completed short item.
    function void apply_item();
        logic [1:0]  kind;
        logic [3:0]  tag;
        logic [63:0] bit_total;
        logic [63:0] byte_total;
        logic [31:0] len;
        kind = item_bits[1:0];
        tag  = item_bits[5:2];
        case (kind)
            ITEM_GLOBAL: begin
                if (tag == TAG_USAGE_PAGE) begin
                    if (!page_seen) begin
                        first_page = item_value[15:0];
                        page_seen  = 1'b1;
                    end
                end else if (tag == TAG_REPORT_SIZE) begin
                    cur_size = item_value;
                end else if (tag == TAG_REPORT_ID) begin
                    cur_id = item_value[7:0];
                end else if (tag == TAG_REPORT_COUNT) begin
                    cur_count = item_value;
                end
            end
            ITEM_LOCAL: begin
                if (tag == TAG_USAGE && !usage_seen) begin
                    first_usage = item_value[15:0];
                    usage_seen  = 1'b1;
                end
            end
            ITEM_MAIN: begin
                if (tag == TAG_INPUT || tag == TAG_OUTPUT || tag == TAG_FEATURE) begin
                    bit_total  = 64'(cur_size) * 64'(cur_count);
                    byte_total = (bit_total + 64'd7) / 64'd8
                                 + ((cur_id != 8'd0) ? 64'd1 : 64'd0);
                    len = (byte_total > 64'hffff_ffff) ? 32'hffff_ffff : byte_total[31:0];
                    if (tag == TAG_INPUT && len > max_input) max_input = len;
                    if (tag == TAG_OUTPUT && len > max_output) max_output = len;
                    if (tag == TAG_FEATURE && len > max_feat) max_feat = len;
                    if (len > max_any) max_any = len;
                end
            end
            default: ;
        endcase
    endfunction

    function void scan_byte(input logic [7:0] b, input logic last);
        t_summary s;
        case (scan_phase)
            SCAN_SHORT_DATA: begin
                item_value = item_value | (32'(b) << (8 * data_pos));
                data_pos   = data_pos + 2'd1;
                bytes_left = bytes_left - 8'd1;
                if (bytes_left == 8'd0) begin
                    apply_item();
                    scan_phase = SCAN_PREFIX;
                end
            end
            SCAN_LONG_LEN: begin
                bytes_left = b;
                scan_phase = SCAN_LONG_TAG;
            end
            SCAN_LONG_TAG: begin
                scan_phase = (bytes_left == 8'd0) ? SCAN_PREFIX : SCAN_LONG_DATA;
            end
            SCAN_LONG_DATA: begin
                bytes_left = bytes_left - 8'd1;
                if (bytes_left == 8'd0) scan_phase = SCAN_PREFIX;
            end
            default: begin
                if (b == LONG_ITEM_PREFIX) begin
                    scan_phase = SCAN_LONG_LEN;
                end else begin
                    item_bits  = b[7:2];
                    item_value = '0;
                    data_pos   = '0;
                    bytes_left = (b[1:0] == SIZE_CODE_FOUR) ? 8'd4 : 8'(b[1:0]);
                    if (bytes_left == 8'd0) begin
                        apply_item();
                        scan_phase = SCAN_PREFIX;
                    end else begin
                        scan_phase = SCAN_SHORT_DATA;
                    end
                end
            end
        endcase
        if (last) begin
            s.input_bytes   = sat16(max_input);
            s.input_ok      = in_range16(max_input);
            s.output_bytes  = sat16(max_output);
            s.output_ok     = in_range16(max_output);
            s.feature_bytes = sat16(max_feat);
            s.feature_ok    = in_range16(max_feat);
            s.upage         = first_page;
            s.usage         = first_usage;
            s.any_bytes     = max_any;
            summary_q.push_back(s);
            clear_scan();
        end
    endfunction

    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    task check_field(input string what, input logic [31:0] got, input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // Values read here are the ones present before the edge, since all drivers use
    // nonblocking assignments.
    always @(posedge i_clk) begin
        t_summary want;
        if (!i_rst_n) begin
            clear_scan();
            summary_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (summary_q.size() == 0) begin
                    report_mismatch("summary with none outstanding", i_max_any_report_bytes,
                                    32'd0);
                end else begin
                    want = summary_q.pop_front();
                    check_field("input_report_bytes", 32'(i_input_report_bytes),
                                32'(want.input_bytes));
                    check_field("input_valid", 32'(i_input_valid), 32'(want.input_ok));
                    check_field("output_report_bytes", 32'(i_output_report_bytes),
                                32'(want.output_bytes));
                    check_field("output_valid", 32'(i_output_valid), 32'(want.output_ok));
                    check_field("feature_report_bytes", 32'(i_feature_report_bytes),
                                32'(want.feature_bytes));
                    check_field("feature_valid", 32'(i_feature_valid), 32'(want.feature_ok));
                    check_field("top_usage_page", 32'(i_top_usage_page), 32'(want.upage));
                    check_field("top_usage", 32'(i_top_usage), 32'(want.usage));
                    check_field("max_any_report_bytes", i_max_any_report_bytes, want.any_bytes);
                end
            end
            if (i_in_valid && !i_in_stall) scan_byte(i_data_byte, i_last_byte);
        end
        o_pending <= summary_q.size();
    end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Top of the bench for hid_report_descriptor_scanner_unit: clock, reset, descriptor
// stimulus and receiver stalls. Depends on the RTL and on bench/hidrds_checker.sv.
module tb;
    import hidrds_bench_pkg::*;

    localparam int BYTE_TARGET     = 600;
    localparam int MIN_DESCRIPTORS = 30;
    localparam int PAUSE_AFTER     = 6;
    localparam int HOLD_AFTER      = 10;
    localparam int HOLD_CYCLES     = 300;
    localparam int HOLD_BURST      = 24;
    localparam int IDLE_LIMIT      = 5000;
    localparam int DRAIN_CYCLES    = 12;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_last_byte = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [15:0] o_input_report_bytes;
    logic        o_input_valid;
    logic [15:0] o_output_report_bytes;
    logic        o_output_valid;
    logic [15:0] o_feature_report_bytes;
    logic        o_feature_valid;
    logic [15:0] o_top_usage_page;
    logic [15:0] o_top_usage;
    logic [31:0] o_max_any_report_bytes;

    int error_count;
    int pending_summaries;

    logic [7:0] descriptor_q[$];
    logic [3:0] report_tags[3] = '{TAG_INPUT, TAG_OUTPUT, TAG_FEATURE};
    int         burst_left       = 0;
    int         bytes_sent       = 0;
    int         descriptors_sent = 0;
    bit         hold_request     = 1'b0;

    hid_report_descriptor_scanner_unit i_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_data_byte           (i_data_byte),
        .i_last_byte           (i_last_byte),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_input_report_bytes  (o_input_report_bytes),
        .o_input_valid         (o_input_valid),
        .o_output_report_bytes (o_output_report_bytes),
        .o_output_valid        (o_output_valid),
        .o_feature_report_bytes(o_feature_report_bytes),
        .o_feature_valid       (o_feature_valid),
        .o_top_usage_page      (o_top_usage_page),
        .o_top_usage           (o_top_usage),
        .o_max_any_report_bytes(o_max_any_report_bytes)
    );

    hidrds_checker u_checker (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .i_in_stall            (o_in_stall),
        .i_data_byte           (i_data_byte),
        .i_last_byte           (i_last_byte),
        .i_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .i_input_report_bytes  (o_input_report_bytes),
        .i_input_valid         (o_input_valid),
        .i_output_report_bytes (o_output_report_bytes),
        .i_output_valid        (o_output_valid),
        .i_feature_report_bytes(o_feature_report_bytes),
        .i_feature_valid       (o_feature_valid),
        .i_top_usage_page      (o_top_usage_page),
        .i_top_usage           (o_top_usage),
        .i_max_any_report_bytes(o_max_any_report_bytes),
        .o_error_count         (error_count),
        .o_pending             (pending_summaries)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Appends a short item; size code 3 carries four data bytes.
    function void add_short(input logic [1:0] kind, input logic [3:0] tag,
                            input logic [1:0] code, input logic [31:0] value);
        int n;
        n = (code == SIZE_CODE_FOUR) ? 4 : int'(code);
        descriptor_q.push_back({tag, kind, code});
        for (int k = 0; k < n; k++) descriptor_q.push_back(value[8*k +: 8]);
    endfunction

    // A size code wide enough for the value, sometimes wider than needed.
    function logic [1:0] fit_code(input logic [31:0] v);
        int needed;
        needed = (v == 0) ? 0 : (v < 256) ? 1 : (v < 65536) ? 2 : 3;
        return 2'($urandom_range(3, needed));
    endfunction

    function logic [31:0] pick_value(input int upper);
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return $urandom();
            2:       return 32'hffff_ffff;
            default: return $urandom_range(upper, 1);
        endcase
    endfunction

    function void add_global(input logic [3:0] tag, input logic [31:0] v);
        add_short(ITEM_GLOBAL, tag, fit_code(v), v);
    endfunction

    function void add_long(input int len);
        descriptor_q.push_back(LONG_ITEM_PREFIX);
        descriptor_q.push_back(8'(len));
        descriptor_q.push_back(8'($urandom()));
        repeat (len) descriptor_q.push_back(8'($urandom()));
    endfunction

    function void build_descriptor();
        logic [31:0] v;
        int          cut;
        descriptor_q.delete();
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(12, 1)) descriptor_q.push_back(8'($urandom()));
        end else begin
            v = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(13, 1);
            add_global(TAG_USAGE_PAGE, v);
            v = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(8, 1);
            add_short(ITEM_LOCAL, TAG_USAGE, fit_code(v), v);
            add_short(ITEM_MAIN, TAG_COLLECTION, 2'd1, 32'd1);
            repeat ($urandom_range(4, 1)) begin
                if ($urandom_range(0, 2) == 0) begin
                    case ($urandom_range(0, 3))
                        0:       v = 32'd0;
                        1:       v = 32'hff;
                        2:       v = $urandom();
                        default: v = $urandom_range(255, 1);
                    endcase
                    add_global(TAG_REPORT_ID, v);
                end
                if ($urandom_range(0, 5) == 0) begin
                    // Lengths right around the 16-bit boundary.
                    add_global(TAG_REPORT_SIZE, 32'd8);
                    add_global(TAG_REPORT_COUNT, $urandom_range(65536, 65533));
                end else begin
                    if ($urandom_range(0, 4) != 0) add_global(TAG_REPORT_SIZE, pick_value(16));
                    if ($urandom_range(0, 4) != 0) add_global(TAG_REPORT_COUNT, pick_value(40));
                end
                repeat ($urandom_range(2, 1))
                    add_short(ITEM_MAIN, report_tags[$urandom_range(2, 0)],
                              2'($urandom_range(3, 0)), $urandom());
                case ($urandom_range(0, 5))
                    0: add_long(($urandom_range(0, 9) == 0) ? $urandom_range(255, 0)
                                                            : $urandom_range(5, 0));
                    1: add_short(ITEM_RESERVED, 4'($urandom()), 2'($urandom()), $urandom());
                    2: add_global(TAG_USAGE_PAGE, $urandom());
                    3: add_short(ITEM_LOCAL, 4'($urandom()), 2'($urandom()), $urandom());
                    default: ;
                endcase
            end
            add_short(ITEM_MAIN, TAG_END_COLLECTION, 2'd0, 32'd0);
            // Now and then the last bytes are cut off, which may stop it in the middle of an item.
            if ($urandom_range(0, 6) == 0) begin
                cut = $urandom_range(3, 1);
                repeat (cut) descriptor_q.pop_back();
            end
        end
    endfunction

    // Offers one item and returns at the edge where it was taken.
    task push_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 5) == 0) ? $urandom_range(12, 4) : $urandom_range(2, 0);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(16, 1);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        burst_left--;
    endtask

    task send_descriptor();
        for (int k = 0; k < descriptor_q.size(); k++)
            push_byte(descriptor_q[k], k == descriptor_q.size() - 1);
        bytes_sent += descriptor_q.size();
        descriptors_sent++;
    endtask

    // The pending count is registered, so it is first read at the edge after the last item.
    task wait_all_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_summaries != 0) @(posedge i_clk);
    endtask

    // Receiver: stretches of different stall density, plus one long hold-off.
    initial begin
        int stretch_left;
        int stall_pct;
        stretch_left = 0;
        stall_pct    = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                if (stretch_left == 0) begin
                    stretch_left = $urandom_range(60, 5);
                    case ($urandom_range(0, 3))
                        0:       stall_pct = 0;
                        1:       stall_pct = 20;
                        2:       stall_pct = 50;
                        default: stall_pct = 90;
                    endcase
                end
                stretch_left--;
                i_out_stall <= ($urandom_range(100, 1) <= stall_pct);
                @(posedge i_clk);
            end
        end
    end

    // Ends the run when neither channel has moved for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        bit paused;
        bit held;
        paused = 1'b0;
        held   = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Two-byte page and usage, zero-data mains with a nine-bit field.
        descriptor_q.delete();
        add_short(ITEM_GLOBAL, TAG_USAGE_PAGE, 2'd2, 32'h1234);
        add_short(ITEM_LOCAL, TAG_USAGE, 2'd2, 32'h5678);
        add_global(TAG_REPORT_SIZE, 32'd1);
        add_global(TAG_REPORT_COUNT, 32'd9);
        add_short(ITEM_MAIN, TAG_INPUT, 2'd0, 32'd0);
        add_short(ITEM_MAIN, TAG_OUTPUT, 2'd0, 32'd0);
        add_short(ITEM_MAIN, TAG_FEATURE, 2'd0, 32'd0);
        send_descriptor();

        // Largest size and count overflow 32 bits; the descriptor ends on an empty
        // long item.
        descriptor_q.delete();
        add_short(ITEM_GLOBAL, TAG_REPORT_SIZE, SIZE_CODE_FOUR, 32'hffff_ffff);
        add_short(ITEM_GLOBAL, TAG_REPORT_COUNT, SIZE_CODE_FOUR, 32'hffff_ffff);
        add_short(ITEM_MAIN, TAG_FEATURE, 2'd0, 32'd0);
        add_long(0);
        send_descriptor();
        wait_all_results();

        while (bytes_sent < BYTE_TARGET || descriptors_sent < MIN_DESCRIPTORS) begin
            build_descriptor();
            send_descriptor();
            if (!paused && descriptors_sent >= PAUSE_AFTER) begin
                paused = 1'b1;
                wait_all_results();
            end
            if (!held && descriptors_sent >= HOLD_AFTER) begin
                // One-byte descriptors pile up behind a receiver that holds off.
                held = 1'b1;
                hold_request = 1'b1;
                burst_left = 1000;
                repeat (HOLD_BURST) begin
                    descriptor_q = '{8'($urandom())};
                    send_descriptor();
                end
                burst_left = 0;
            end
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_summaries == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
